>>> hdl/assert_macros.svh
// Assertion helpers used by the top RTL file of the phase rotator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every rising clock edge outside reset.
`define FSR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fsr assertion failed");

// Condition that must never be seen outside reset.
`define FSR_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("fsr forbidden condition seen");

`else

`define FSR_ASSERT(label, clk, rst_n, prop)
`define FSR_NEVER(label, clk, rst_n, cond)

`endif

`endif

>>> hdl/fsr_pkg.sv
package fsr_pkg;

    // Default configuration of the rotator.
    localparam int SAMPLE_BITS_DEF   = 18;
    localparam int FREQ_BITS_DEF     = 10;
    localparam int CORDIC_STAGES_DEF = 16;

    // Fixed widths of the arithmetic.
    localparam int GUARD_BITS    = 8;
    localparam int ATAN_ENTRIES  = 24;
    localparam int ANGLE_BITS    = 32;
    localparam int SHIFT_BITS    = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int GAIN_FRAC     = 30;
    localparam int GAIN_SPLIT    = 15;

    // Eighth-turn offset used to pick the nearest quadrant.
    localparam logic [SHIFT_BITS-1:0] QUAD_OFFSET = 16'h2000;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SHIFT_X,
        REG_SHIFT_Y
    } t_reg_idx;

    // atan(2^-i) where 2^32 is one full turn.
    localparam logic [ANGLE_BITS-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Number of CORDIC iterations actually built.
    function automatic int stage_count(input int n);
        return (n > ATAN_ENTRIES) ? ATAN_ENTRIES : n;
    endfunction

    // Inverse CORDIC gain in Q30, evaluated at elaboration.
    function automatic logic [63:0] gain_q30(input int n);
        logic [63:0] p;
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] s;
        logic [63:0] num;
        logic [63:0] quo;
        logic [64:0] drem;
        p = 64'd1 << 60;
        for (int i = 0; i < n; i++) begin
            p = p + (p >> (2 * i));
        end
        // Integer square root, two bits per step.
        rem  = p;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        s = (res == 64'd0) ? 64'd1 : res;
        // Rounded quotient by restoring long division.
        num  = (64'd1 << 60) + (s >> 1);
        quo  = '0;
        drem = '0;
        for (int k = 63; k >= 0; k--) begin
            drem = {drem[63:0], num[k]};
            if (drem >= {1'b0, s}) begin
                drem   = drem - {1'b0, s};
                quo[k] = 1'b1;
            end
        end
        return quo;
    endfunction

endpackage

>>> hdl/fsr_ifs.sv
// Input request channel: one spectrum coefficient with its wave numbers.
interface fsr_in_if #(
    parameter int SAMPLE_BITS = fsr_pkg::SAMPLE_BITS_DEF,
    parameter int FREQ_BITS   = fsr_pkg::FREQ_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_real;
    logic signed [SAMPLE_BITS-1:0] sample_imag;
    logic signed [FREQ_BITS-1:0]   row_freq;
    logic signed [FREQ_BITS-1:0]   col_freq;

    modport source (output valid, sample_real, sample_imag, row_freq, col_freq, input ready);
    modport sink   (input valid, sample_real, sample_imag, row_freq, col_freq, output ready);
endinterface

// Output request channel: the rotated coefficient and its clip flag.
interface fsr_out_if #(
    parameter int SAMPLE_BITS = fsr_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_real;
    logic signed [SAMPLE_BITS-1:0] out_imag;
    logic                          saturated;

    modport source (output valid, out_real, out_imag, saturated, input ready);
    modport sink   (input valid, out_real, out_imag, saturated, output ready);
endinterface

// Configuration write channel.
interface fsr_cfg_if;
    import fsr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/fourier_shift_phase_rotator.sv
// Datapath: an accepted request passes the phase, quadrant, CORDIC and gain stages in that order.
// Throughput: one request per cycle while the output is not stalled; phase, quadrant, every CORDIC iteration and the
// three gain stages each own a register stage, and valid bits flow with the data.
// A stalled output fills empty stages first and holds the rest without loss.
// Reset: synchronous, active-low i_rst_n empties the pipeline and clears shift_x and shift_y.
`include "assert_macros.svh"

module fourier_shift_phase_rotator #(
    parameter int SAMPLE_BITS   = fsr_pkg::SAMPLE_BITS_DEF,
    parameter int FREQ_BITS     = fsr_pkg::FREQ_BITS_DEF,
    parameter int CORDIC_STAGES = fsr_pkg::CORDIC_STAGES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fsr_cfg_if.sink    i_cfg,
    fsr_in_if.sink     i_in,
    fsr_out_if.source  o_out
);
    import fsr_pkg::*;

    localparam int N_STAGES = stage_count(CORDIC_STAGES);
    localparam int XW       = SAMPLE_BITS + GUARD_BITS + 3;
    localparam int PRW      = SHIFT_BITS + FREQ_BITS;
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_90,
        QUAD_180,
        QUAD_270
    } t_quad;

    logic signed [SHIFT_BITS-1:0]  r_shift_x;
    logic signed [SHIFT_BITS-1:0]  r_shift_y;

    logic                          r_a_valid;
    logic signed [SAMPLE_BITS-1:0] r_a_re;
    logic signed [SAMPLE_BITS-1:0] r_a_im;
    logic [SHIFT_BITS-1:0]         r_a_phase;
    logic signed [PRW-1:0]         w_prod_x;
    logic signed [PRW-1:0]         w_prod_y;
    logic [SHIFT_BITS-1:0]         n_phase;
    logic                          w_ready_a;

    logic                          r_b_valid;
    logic signed [XW-1:0]          r_b_x;
    logic signed [XW-1:0]          r_b_y;
    logic signed [ANGLE_BITS-1:0]  r_b_z;
    logic                          w_ready_b;
    logic [SHIFT_BITS-1:0]         w_quad_sum;
    t_quad                         w_quad;
    logic signed [SHIFT_BITS-1:0]  w_resid;
    logic signed [SAMPLE_BITS:0]   w_ext_re;
    logic signed [SAMPLE_BITS:0]   w_ext_im;
    logic signed [SAMPLE_BITS:0]   w_rot_re;
    logic signed [SAMPLE_BITS:0]   w_rot_im;

    logic                          w_cv   [N_STAGES+1];
    logic                          w_crdy [N_STAGES+1];
    logic signed [XW-1:0]          w_cx   [N_STAGES+1];
    logic signed [XW-1:0]          w_cy   [N_STAGES+1];
    logic signed [ANGLE_BITS-1:0]  w_cz   [N_STAGES+1];

    // Configuration registers; writes outside the list are dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_x <= '0;
            r_shift_y <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_SHIFT_X: r_shift_x <= i_cfg.data;
                REG_SHIFT_Y: r_shift_y <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Stage A: binary-angle phase, wrapping modulo one turn.
    assign w_ready_a  = !r_a_valid || w_ready_b;
    assign i_in.ready = w_ready_a;
    assign w_prod_y   = r_shift_y * i_in.row_freq;
    assign w_prod_x   = r_shift_x * i_in.col_freq;
    assign n_phase    = w_prod_y[SHIFT_BITS-1:0] + w_prod_x[SHIFT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_ready_a) begin
            r_a_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_a && i_in.valid) begin
            r_a_re    <= i_in.sample_real;
            r_a_im    <= i_in.sample_imag;
            r_a_phase <= n_phase;
        end
    end

    // Stage B: exact quarter-turn pre-rotation and the residual angle.
    assign w_ready_b  = !r_b_valid || w_crdy[0];
    assign w_quad_sum = r_a_phase + QUAD_OFFSET;
    assign w_quad     = t_quad'(w_quad_sum[SHIFT_BITS-1:SHIFT_BITS-2]);
    assign w_resid    = r_a_phase - {w_quad_sum[SHIFT_BITS-1:SHIFT_BITS-2],
                                     (SHIFT_BITS-2)'(0)};
    assign w_ext_re   = (SAMPLE_BITS+1)'(r_a_re);
    assign w_ext_im   = (SAMPLE_BITS+1)'(r_a_im);

    always_comb begin
        case (w_quad)
            QUAD_90: begin
                w_rot_re = -w_ext_im;
                w_rot_im = w_ext_re;
            end
            QUAD_180: begin
                w_rot_re = -w_ext_re;
                w_rot_im = -w_ext_im;
            end
            QUAD_270: begin
                w_rot_re = w_ext_im;
                w_rot_im = -w_ext_re;
            end
            default: begin
                w_rot_re = w_ext_re;
                w_rot_im = w_ext_im;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_ready_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_b && r_a_valid) begin
            r_b_x <= XW'(w_rot_re) <<< GUARD_BITS;
            r_b_y <= XW'(w_rot_im) <<< GUARD_BITS;
            r_b_z <= ANGLE_BITS'(w_resid) <<< SHIFT_BITS;
        end
    end

    // CORDIC: one iteration per pipeline stage.
    assign w_cv[0] = r_b_valid;
    assign w_cx[0] = r_b_x;
    assign w_cy[0] = r_b_y;
    assign w_cz[0] = r_b_z;

    for (genvar g = 0; g < N_STAGES; g++) begin : g_cordic
        fsr_cordic #(
            .XW    (XW),
            .SHIFT (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_cv[g]),
            .o_ready (w_crdy[g]),
            .i_x     (w_cx[g]),
            .i_y     (w_cy[g]),
            .i_z     (w_cz[g]),
            .o_valid (w_cv[g+1]),
            .i_ready (w_crdy[g+1]),
            .o_x     (w_cx[g+1]),
            .o_y     (w_cy[g+1]),
            .o_z     (w_cz[g+1])
        );
    end

    // Gain correction, rounding and saturation; its last stage is the output register.
    fsr_scale #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .XW          (XW),
        .N_STAGES    (N_STAGES)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cv[N_STAGES]),
        .o_ready (w_crdy[N_STAGES]),
        .i_x     (w_cx[N_STAGES]),
        .i_y     (w_cy[N_STAGES]),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_real  (o_out.out_real),
        .o_imag  (o_out.out_imag),
        .o_sat   (o_out.saturated)
    );

    // A stalled phase stage keeps its request.
    `FSR_ASSERT(a_phase_hold, i_clk, i_rst_n, r_a_valid && !w_ready_b |=> r_a_valid && $stable(r_a_phase))
    // Input backpressure only comes from a full pipeline behind a stalled output.
    `FSR_NEVER(a_ready_cause, i_clk, i_rst_n, !i_in.ready && !(o_out.valid && !o_out.ready))
    // A clipped result sits at a range limit in at least one part.
    `FSR_ASSERT(a_sat_limit, i_clk, i_rst_n, o_out.valid && o_out.saturated |-> (o_out.out_real == S_MAX || o_out.out_real == S_MIN || o_out.out_imag == S_MAX || o_out.out_imag == S_MIN))

endmodule

>>> hdl/fsr_cordic.sv
module fsr_cordic #(
    parameter int XW    = 29,
    parameter int SHIFT = 0
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [XW-1:0]                 i_x,
    input  logic signed [XW-1:0]                 i_y,
    input  logic signed [fsr_pkg::ANGLE_BITS-1:0] i_z,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [XW-1:0]                 o_x,
    output logic signed [XW-1:0]                 o_y,
    output logic signed [fsr_pkg::ANGLE_BITS-1:0] o_z
);
    import fsr_pkg::*;

    localparam logic signed [ANGLE_BITS-1:0] ATAN = ATAN_TAB[SHIFT];

    logic                         r_valid;
    logic signed [XW-1:0]         r_x;
    logic signed [XW-1:0]         r_y;
    logic signed [ANGLE_BITS-1:0] r_z;
    logic signed [XW-1:0]         n_x;
    logic signed [XW-1:0]         n_y;
    logic signed [ANGLE_BITS-1:0] n_z;
    logic signed [XW-1:0]         w_dx;
    logic signed [XW-1:0]         w_dy;
    logic                         w_dir;
    logic                         w_load;

    // The stage takes a new request when empty or when its content moves on.
    assign w_load  = !r_valid || i_ready;
    assign o_ready = w_load;

    // One micro-rotation toward zero residual angle; the shifts round toward minus infinity.
    assign w_dx  = i_y >>> SHIFT;
    assign w_dy  = i_x >>> SHIFT;
    assign w_dir = !i_z[ANGLE_BITS-1];

    always_comb begin
        if (w_dir) begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

>>> hdl/fsr_scale.sv
module fsr_scale #(
    parameter int SAMPLE_BITS = 18,
    parameter int XW          = 29,
    parameter int N_STAGES    = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [XW-1:0]          i_x,
    input  logic signed [XW-1:0]          i_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_real,
    output logic signed [SAMPLE_BITS-1:0] o_imag,
    output logic                          o_sat
);
    import fsr_pkg::*;

    localparam logic [63:0] K_GAIN = gain_q30(N_STAGES);
    localparam logic [GAIN_SPLIT-1:0] K_HI = K_GAIN[2*GAIN_SPLIT-1:GAIN_SPLIT];
    localparam logic [GAIN_SPLIT-1:0] K_LO = K_GAIN[GAIN_SPLIT-1:0];
    localparam int PW = XW + GAIN_SPLIT;
    localparam int RW = PW + 1;
    localparam int SH = GAIN_FRAC + GUARD_BITS - GAIN_SPLIT;
    localparam logic [RW-1:0] ROUND   = RW'(1) << (SH - 1);
    localparam logic [RW-1:0] LIM_POS = (RW'(1) << (SAMPLE_BITS - 1)) - RW'(1);
    localparam logic [RW-1:0] LIM_NEG = RW'(1) << (SAMPLE_BITS - 1);
    localparam logic [SAMPLE_BITS-1:0] S_MAX = LIM_POS[SAMPLE_BITS-1:0];
    localparam logic [SAMPLE_BITS-1:0] S_MIN = LIM_NEG[SAMPLE_BITS-1:0];

    logic                   r_v1;
    logic                   r_v2;
    logic                   r_v3;
    logic                   w_rdy1;
    logic                   w_rdy2;
    logic                   w_rdy3;
    logic [XW-1:0]          r_mx;
    logic [XW-1:0]          r_my;
    logic                   r_neg_x1;
    logic                   r_neg_y1;
    logic [PW-1:0]          r_ax;
    logic [PW-1:0]          r_bx;
    logic [PW-1:0]          r_ay;
    logic [PW-1:0]          r_by;
    logic                   r_neg_x2;
    logic                   r_neg_y2;
    logic [XW-1:0]          w_ux;
    logic [XW-1:0]          w_uy;
    logic [RW-1:0]          w_rx;
    logic [RW-1:0]          w_ry;
    logic                   w_sat_x;
    logic                   w_sat_y;
    logic [SAMPLE_BITS-1:0] n_real;
    logic [SAMPLE_BITS-1:0] n_imag;
    logic [SAMPLE_BITS-1:0] r_real;
    logic [SAMPLE_BITS-1:0] r_imag;
    logic                   r_sat;

    // Each stage moves when it is empty or the next one takes its content.
    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Stage one: sign and magnitude.
    assign w_ux = i_x;
    assign w_uy = i_y;

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_valid) begin
            r_mx     <= i_x[XW-1] ? (~w_ux + XW'(1)) : w_ux;
            r_my     <= i_y[XW-1] ? (~w_uy + XW'(1)) : w_uy;
            r_neg_x1 <= i_x[XW-1];
            r_neg_y1 <= i_y[XW-1];
        end
    end

    // Stage two: magnitude times the gain, split into two narrow products.
    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r_ax     <= PW'(r_mx) * PW'(K_HI);
            r_bx     <= PW'(r_mx) * PW'(K_LO);
            r_ay     <= PW'(r_my) * PW'(K_HI);
            r_by     <= PW'(r_my) * PW'(K_LO);
            r_neg_x2 <= r_neg_x1;
            r_neg_y2 <= r_neg_y1;
        end
    end

    // Stage three: round half away from zero, restore the sign and clip.
    assign w_rx = (RW'(r_ax) + ROUND + RW'(r_bx >> GAIN_SPLIT)) >> SH;
    assign w_ry = (RW'(r_ay) + ROUND + RW'(r_by >> GAIN_SPLIT)) >> SH;
    assign w_sat_x = r_neg_x2 ? (w_rx > LIM_NEG) : (w_rx > LIM_POS);
    assign w_sat_y = r_neg_y2 ? (w_ry > LIM_NEG) : (w_ry > LIM_POS);

    always_comb begin
        if (w_sat_x) begin
            n_real = r_neg_x2 ? S_MIN : S_MAX;
        end else begin
            n_real = r_neg_x2 ? (~w_rx[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1))
                              : w_rx[SAMPLE_BITS-1:0];
        end
        if (w_sat_y) begin
            n_imag = r_neg_y2 ? S_MIN : S_MAX;
        end else begin
            n_imag = r_neg_y2 ? (~w_ry[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1))
                              : w_ry[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_v2) begin
            r_real <= n_real;
            r_imag <= n_imag;
            r_sat  <= w_sat_x || w_sat_y;
        end
    end

    assign o_valid = r_v3;
    assign o_real  = r_real;
    assign o_imag  = r_imag;
    assign o_sat   = r_sat;

endmodule

>>> verif/tb_fourier_shift_phase_rotator.sv
module tb_fourier_shift_phase_rotator;
    timeunit 1ns;
    timeprecision 1ps;

    import fsr_pkg::*;

    localparam int SW = SAMPLE_BITS_DEF;
    localparam int FW = FREQ_BITS_DEF;
    localparam int ITERATIONS = (CORDIC_STAGES_DEF > ATAN_ENTRIES) ? ATAN_ENTRIES
                                                                   : CORDIC_STAGES_DEF;
    localparam int LATENCY         = ITERATIONS + 5;
    localparam int HOLD_CYCLES     = 200;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int MAX_REPORTS     = 50;
    localparam int SCALE_SHIFT     = GAIN_FRAC + GUARD_BITS;

    localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [FW-1:0] FREQ_MAX   = {1'b0, {(FW-1){1'b1}}};
    localparam logic signed [FW-1:0] FREQ_MIN   = {1'b1, {(FW-1){1'b0}}};

    // Indexes past the register list; writes to them must change nothing.
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_HI = 2'd3;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_90,
        QUAD_180,
        QUAD_270
    } quadrant_e;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic signed [SW-1:0] re;
        logic signed [SW-1:0] im;
        logic signed [FW-1:0] row;
        logic signed [FW-1:0] col;
    } coef_t;

    typedef struct packed {
        logic signed [SW-1:0] re;
        logic signed [SW-1:0] im;
        logic                 sat;
    } rotated_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fsr_cfg_if cfg_bus ();
    fsr_in_if  in_bus ();
    fsr_out_if out_bus ();

    fourier_shift_phase_rotator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // Arctangent of 2^-i, with 2^32 as one full turn.
    longint arctan_step [ATAN_ENTRIES] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    u64_t                     inverse_gain;
    logic [CFG_DATA_BITS-1:0] shift_x_q;
    logic [CFG_DATA_BITS-1:0] shift_y_q;

    coef_t    pending_coefs [$];
    rotated_t expected_rotations [$];
    coef_t    held_coef;
    rotated_t want_rot;

    int  coefs_queued;
    int  coefs_accepted;
    int  results_checked;
    int  clipped_results;
    int  mismatch_count;
    int  settings_run;
    int  reg_writes;
    int  sender_max_gap;
    int  receiver_max_stall;
    int  send_gap_left;
    int  recv_stall_left;
    int  idle_cycles;
    bit  pressure_armed;
    logic hold_output;

    // Clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Inverse of the CORDIC gain in Q30, from the stage product in Q60.
    function automatic u64_t inverse_gain_q30(int n);
        u64_t prod;
        u64_t root;
        u64_t trial;
        prod = u64_t'(1) << 60;
        for (int i = 0; i < n; i++) begin
            prod += prod >> (2 * i);
        end
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (u64_t'(1) << b);
            if (trial * trial <= prod) begin
                root = trial;
            end
        end
        if (root == 0) begin
            root = 1;
        end
        return ((u64_t'(1) << 60) + (root >> 1)) / root;
    endfunction

    // Gain correction with guard bits dropped, rounded half away from zero.
    function automatic longint scale_to_sample(longint v);
        u64_t mag;
        u64_t hi_part;
        u64_t lo_part;
        u64_t rounded;
        mag     = (v < 0) ? u64_t'(-v) : u64_t'(v);
        hi_part = mag * (inverse_gain >> GAIN_SPLIT);
        lo_part = mag * (inverse_gain & ((u64_t'(1) << GAIN_SPLIT) - 1));
        rounded = (hi_part + (u64_t'(1) << (SCALE_SHIFT - 16)) + (lo_part >> GAIN_SPLIT))
                  >> (SCALE_SHIFT - GAIN_SPLIT);
        return (v < 0) ? -longint'(rounded) : longint'(rounded);
    endfunction

    function automatic logic signed [SW-1:0] clip_to_sample(longint v, inout bit clipped);
        longint top;
        longint bottom;
        top    = (longint'(1) <<< (SW - 1)) - 1;
        bottom = -top - 1;
        if (v > top) begin
            clipped = 1'b1;
            return SAMPLE_MAX;
        end
        if (v < bottom) begin
            clipped = 1'b1;
            return SAMPLE_MIN;
        end
        return SW'(v);
    endfunction

    // Expected rotation of one coefficient under the current shifts.
    function automatic rotated_t rotate_coef(coef_t c);
        longint    re;
        longint    im;
        longint    swap;
        longint    x;
        longint    y;
        longint    z;
        longint    dx;
        longint    dy;
        logic [SHIFT_BITS-1:0] angle;
        logic [SHIFT_BITS-1:0] resid;
        logic [SHIFT_BITS-1:0] rounded_angle;
        quadrant_e quad;
        bit        clipped;
        rotated_t  r;
        re    = longint'($signed(c.re));
        im    = longint'($signed(c.im));
        angle = SHIFT_BITS'(longint'($signed(shift_y_q)) * longint'($signed(c.row))
                          + longint'($signed(shift_x_q)) * longint'($signed(c.col)));
        // Nearest quarter turn is taken exactly; the rest goes to the CORDIC.
        rounded_angle = angle + 16'h2000;
        quad  = quadrant_e'(rounded_angle[SHIFT_BITS-1 -: 2]);
        resid = angle - {rounded_angle[SHIFT_BITS-1 -: 2], 14'b0};
        case (quad)
            QUAD_90: begin
                swap = re;
                re   = -im;
                im   = swap;
            end
            QUAD_180: begin
                re = -re;
                im = -im;
            end
            QUAD_270: begin
                swap = re;
                re   = im;
                im   = -swap;
            end
            default: begin
            end
        endcase
        x = re * (longint'(1) <<< GUARD_BITS);
        y = im * (longint'(1) <<< GUARD_BITS);
        z = longint'($signed(resid)) * 65536;
        for (int i = 0; i < ITERATIONS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= arctan_step[i];
            end else begin
                x += dx;
                y -= dy;
                z += arctan_step[i];
            end
        end
        clipped = 1'b0;
        r.re  = clip_to_sample(scale_to_sample(x), clipped);
        r.im  = clip_to_sample(scale_to_sample(y), clipped);
        r.sat = clipped;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // Sample value biased toward the range ends and values near zero.
    function automatic logic signed [SW-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return SW'(int'($urandom_range(0, 32)) - 16);
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic logic signed [FW-1:0] pick_freq();
        case ($urandom_range(0, 7))
            0: return FREQ_MAX;
            1: return FREQ_MIN;
            2: return FW'(int'($urandom_range(0, 8)) - 4);
            default: return FW'($urandom);
        endcase
    endfunction

    task automatic queue_coef(logic signed [SW-1:0] re, logic signed [SW-1:0] im,
                              logic signed [FW-1:0] row, logic signed [FW-1:0] col);
        coef_t c;
        c.re  = re;
        c.im  = im;
        c.row = row;
        c.col = col;
        pending_coefs = {pending_coefs, c};
        coefs_queued++;
    endtask

    // One register write request; the local copy follows the block's decode.
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
        @(posedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        reg_writes++;
        if (idx == REG_SHIFT_X) begin
            shift_x_q = value;
        end else if (idx == REG_SHIFT_Y) begin
            shift_y_q = value;
        end
    endtask

    task automatic set_pacing(int send_max, int recv_max);
        sender_max_gap     = send_max;
        receiver_max_stall = recv_max;
    endtask

    // Wait until every queued request has come back, then let the pipe settle.
    task automatic drain_pipeline();
        wait (coefs_accepted == coefs_queued && expected_rotations.size() == 0);
        repeat (LATENCY) @(posedge i_clk);
        settings_run++;
    endtask

    // Input driver: takes requests from the pending queue with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid  <= 1'b0;
            send_gap_left <= 0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                expected_rotations = {expected_rotations, rotate_coef(held_coef)};
                coefs_accepted++;
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (send_gap_left > 0) begin
                    send_gap_left <= send_gap_left - 1;
                    in_bus.valid  <= 1'b0;
                end else if (pending_coefs.size() > 0) begin
                    held_coef = pending_coefs.pop_front();
                    in_bus.sample_real <= held_coef.re;
                    in_bus.sample_imag <= held_coef.im;
                    in_bus.row_freq    <= held_coef.row;
                    in_bus.col_freq    <= held_coef.col;
                    in_bus.valid       <= 1'b1;
                    send_gap_left      <= $urandom_range(0, sender_max_gap);
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each result against the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready   <= 1'b0;
            recv_stall_left = 0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (expected_rotations.size() == 0) begin
                    report_mismatch($sformatf("result (%0d, %0d) with nothing expected",
                                              out_bus.out_real, out_bus.out_imag));
                end else begin
                    want_rot = expected_rotations.pop_front();
                    results_checked++;
                    if (want_rot.sat) begin
                        clipped_results++;
                    end
                    if (out_bus.out_real !== want_rot.re) begin
                        report_mismatch($sformatf("result %0d real: got %0d, expected %0d",
                                                  results_checked, out_bus.out_real,
                                                  want_rot.re));
                    end
                    if (out_bus.out_imag !== want_rot.im) begin
                        report_mismatch($sformatf("result %0d imag: got %0d, expected %0d",
                                                  results_checked, out_bus.out_imag,
                                                  want_rot.im));
                    end
                    if (out_bus.saturated !== want_rot.sat) begin
                        report_mismatch($sformatf("result %0d clip flag: got %b, expected %b",
                                                  results_checked, out_bus.saturated,
                                                  want_rot.sat));
                    end
                end
                recv_stall_left = $urandom_range(0, receiver_max_stall);
            end else if (recv_stall_left > 0) begin
                recv_stall_left--;
            end
            out_bus.ready <= (recv_stall_left == 0) && !hold_output;
        end
    end

    // Long output hold-off so the pipeline fills and backs up the input.
    initial begin
        hold_output = 1'b0;
        wait (pressure_armed);
        @(posedge i_clk);
        hold_output <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_output <= 1'b0;
    end

    // Watchdog on cycles in which no request moves on any channel.
    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no request moved for %0d cycles.", idle_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus sequence.
    initial begin
        i_rst_n            = 1'b0;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = '0;
        cfg_bus.data       = '0;
        in_bus.valid       = 1'b0;
        in_bus.sample_real = '0;
        in_bus.sample_imag = '0;
        in_bus.row_freq    = '0;
        in_bus.col_freq    = '0;
        out_bus.ready      = 1'b0;
        shift_x_q          = '0;
        shift_y_q          = '0;
        coefs_queued       = 0;
        coefs_accepted     = 0;
        results_checked    = 0;
        clipped_results    = 0;
        mismatch_count     = 0;
        settings_run       = 0;
        reg_writes         = 0;
        idle_cycles        = 0;
        pressure_armed     = 1'b0;
        inverse_gain       = inverse_gain_q30(ITERATIONS);
        set_pacing(4, 4);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset shifts: no rotation, only gain and rounding.
        queue_coef(SAMPLE_MAX, SAMPLE_MAX, FREQ_MAX, FREQ_MIN);
        queue_coef(SAMPLE_MIN, SAMPLE_MIN, FREQ_MIN, FREQ_MAX);
        drain_pipeline();

        // Quarter-turn column shift reaches every quadrant; half-quadrant row shift
        // lands on the quadrant boundary.
        write_reg(REG_SHIFT_X, 16'h4000);
        write_reg(REG_SHIFT_Y, 16'h2000);
        queue_coef(SAMPLE_MAX, '0, '0, FW'(1));
        queue_coef(SAMPLE_MIN, SAMPLE_MIN, '0, FW'(2));
        queue_coef(SAMPLE_MAX, SAMPLE_MIN, '0, FW'(3));
        queue_coef(SAMPLE_MAX, SAMPLE_MAX, FW'(1), '0);
        queue_coef(SW'(-5), SW'(7), '0, FW'(-1));
        queue_coef(SW'(1), SW'(-1), FW'(1), FW'(1));
        queue_coef(SAMPLE_MIN, SAMPLE_MAX, FREQ_MAX, FREQ_MAX);
        queue_coef('0, '0, FREQ_MIN, FREQ_MIN);
        drain_pipeline();

        // Largest residual angle, half-turn row shift, and writes past the list.
        write_reg(REG_SHIFT_X, 16'h1FFF);
        write_reg(REG_SHIFT_Y, 16'h8000);
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h5555);
        queue_coef(SAMPLE_MAX, SAMPLE_MAX, '0, FW'(1));
        queue_coef(SAMPLE_MIN, SAMPLE_MAX, FW'(1), '0);
        queue_coef(SW'(1000), SW'(-1000), FW'(-1), FW'(1));
        queue_coef(SAMPLE_MAX, SAMPLE_MIN, FREQ_MIN, FREQ_MIN);
        queue_coef(SAMPLE_MIN, '0, FREQ_MAX, FW'(-1));
        drain_pipeline();

        // Largest positive shifts with extreme wave numbers wrap the phase.
        write_reg(REG_SHIFT_X, 16'h7FFF);
        write_reg(REG_SHIFT_Y, 16'h7FFF);
        queue_coef(SAMPLE_MAX, SAMPLE_MAX, FREQ_MAX, FREQ_MAX);
        queue_coef(SAMPLE_MIN, SAMPLE_MIN, FREQ_MIN, FREQ_MIN);
        queue_coef(SW'(12345), SW'(-54321), FW'(-1), FW'(-1));
        queue_coef(SAMPLE_MAX, SW'(1), FREQ_MAX, FREQ_MIN);
        drain_pipeline();

        // Random phases, each of which writes new shifts and sets a pacing.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                2: begin
                    write_reg(REG_SHIFT_X, 16'h7FFF);
                    write_reg(REG_SHIFT_Y, 16'h8000);
                end
                5: begin
                    write_reg(REG_SHIFT_X, 16'h8000);
                    write_reg(REG_SHIFT_Y, 16'h7FFF);
                end
                6: begin
                    write_reg(REG_SHIFT_Y, '0);
                    write_reg(REG_SHIFT_X, CFG_DATA_BITS'($urandom));
                end
                default: begin
                    write_reg(REG_SHIFT_X, CFG_DATA_BITS'($urandom));
                    write_reg(REG_SHIFT_Y, CFG_DATA_BITS'($urandom));
                end
            endcase
            if (p == 3) begin
                write_reg(REG_SPARE_HI, CFG_DATA_BITS'($urandom));
                write_reg(REG_SPARE_LO, CFG_DATA_BITS'($urandom));
            end
            case (p % 4)
                0: set_pacing(10, 10);
                1: set_pacing(0, 0);
                2: set_pacing(0, 10);
                default: set_pacing(10, 0);
            endcase
            if (p == 1) begin
                pressure_armed = 1'b1;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                queue_coef(pick_sample(), pick_sample(), pick_freq(), pick_freq());
            end
            drain_pipeline();
        end

        $display("Covered %0d coefficients over %0d shift settings (%0d register writes).",
                 results_checked, settings_run, reg_writes);
        $display("%0d results clipped; output held off once for %0d cycles; %0d mismatches.",
                 clipped_results, HOLD_CYCLES, mismatch_count);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> fourier_shift_phase_rotator.f
+incdir+hdl
hdl/fsr_pkg.sv
hdl/fsr_ifs.sv
hdl/fsr_cordic.sv
hdl/fsr_scale.sv
hdl/fourier_shift_phase_rotator.sv
verif/tb_fourier_shift_phase_rotator.sv
